FILE: rtl/core/skvt_pkg.sv
`default_nettype none
package skvt_pkg;
  localparam int DefCapacity = 32;
  localparam int KeyW = 32;
  localparam int ValW = 32;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_REMOVE = 2'd2,
    FN_DUMP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    func_t            func;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  value;
  } cmd_t;

  // signed order compare on raw patterns
  function automatic logic key_gt(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
    key_gt = $signed(a) > $signed(b);
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/skvt_cmd_fifo.sv
`default_nettype none
module skvt_cmd_fifo
  import skvt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire cmd_t in_cmd,
  output logic      out_valid,
  input  wire logic out_take,
  output cmd_t      out_cmd
);
  // two-entry queue between front and back
  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push, pop;

  assign in_stall  = (fill == 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_cmd   = slots[rd_ptr];
  assign push = in_valid && !in_stall;
  assign pop  = out_valid && out_take;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/skvt_engine.sv
`default_nettype none
module skvt_engine
  import skvt_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
)
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_take,
  input  wire cmd_t             cmd,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            status,
  output logic                  found,
  output logic signed [31:0]    data_out,
  output logic                  last
);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_INS, S_DEL, S_DUMP, S_OUT
  } state_t;

  state_t          state;
  cmd_t            cur;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   pos;
  logic [KeyW-1:0] keys [CAPACITY];
  logic [ValW-1:0] vals [CAPACITY];
  logic [KeyW-1:0] rd_key;
  logic [ValW-1:0] rd_val;
  logic            out_free;
  logic            emit_word;
  logic            scan_stop;
  logic            scan_hit;
  logic [CW-1:0]   ins_src;

  // read data of the memories, registered
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [KeyW-1:0] wr_key;
  logic [ValW-1:0] wr_val;

  assign out_free  = !out_valid || !out_stall;
  assign emit_word = ((state == S_DUMP) || (state == S_OUT)) && out_free;
  // next word only once the previous result has left
  assign cmd_take  = (state == S_IDLE) && cmd_valid && !out_valid;
  assign ins_src   = idx - CW'(1);
  assign scan_stop = (idx == count) || (rd_key == cur.key) || key_gt(rd_key, cur.key);
  assign scan_hit  = (idx != count) && (rd_key == cur.key);

  // read address for next cycle's data
  always_comb begin
    rd_addr = idx[IW-1:0];
    case (state)
      S_IDLE:  rd_addr = '0;
      // an insert shift starts from the top entry
      S_SCAN:  rd_addr = (scan_stop && cur.func == FN_INSERT) ?
                         count[IW-1:0] - IW'(1) : idx[IW-1:0] + IW'(1);
      S_INS:   rd_addr = ins_src[IW-1:0] - IW'(1);
      S_DEL:   rd_addr = idx[IW-1:0] + IW'(2);
      S_DUMP:  rd_addr = out_free ? idx[IW-1:0] + IW'(1) : idx[IW-1:0];
      default: rd_addr = idx[IW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    rd_key <= keys[rd_addr];
    rd_val <= vals[rd_addr];
    if (wr_en) begin
      keys[wr_addr] <= wr_key;
      vals[wr_addr] <= wr_val;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[IW-1:0];
    wr_key  = rd_key;
    wr_val  = rd_val;
    case (state)
      S_INS: begin
        wr_en = 1'b1;
        if (idx == pos) begin
          wr_key = cur.key;
          wr_val = cur.value;
        end
      end
      S_DEL:   wr_en = (idx + CW'(1) < count);
      default: wr_en = 1'b0;
    endcase
  end

  // S_INS: idx walks from count down to insert point; rd holds entry idx-1.
  // Insert point written last with the new pair; pos holds the insert point.

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !emit_word) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            cur <= cmd;
            idx <= '0;
            if (cmd.func == FN_DUMP) begin
              if (count == '0) begin
                status <= ST_MISS; found <= 1'b0; data_out <= '0; last <= 1'b1;
                state <= S_OUT;
              end else begin
                state <= S_DUMP;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // rd_key holds entry idx
          if (scan_stop) begin
            last <= 1'b1;
            case (cur.func)
              FN_INSERT: begin
                found    <= 1'b0;
                data_out <= '0;
                if (scan_hit) begin
                  status <= ST_DUP; state <= S_OUT;
                end else if (count == CW'(CAPACITY)) begin
                  status <= ST_FULL; state <= S_OUT;
                end else begin
                  status <= ST_OK;
                  pos    <= idx;
                  idx    <= count;
                  state  <= S_INS;
                end
              end
              FN_LOOKUP: begin
                if (scan_hit) begin
                  status <= ST_OK; found <= 1'b1; data_out <= rd_val;
                end else begin
                  status <= ST_MISS; found <= 1'b0; data_out <= '0;
                end
                state <= S_OUT;
              end
              default: begin
                data_out <= '0;
                if (scan_hit) begin
                  status <= ST_OK; found <= 1'b1;
                  state <= S_DEL;
                end else begin
                  status <= ST_MISS; found <= 1'b0;
                  state <= S_OUT;
                end
              end
            endcase
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_INS: begin
          if (idx == pos) begin
            count <= count + CW'(1);
            state <= S_OUT;
          end else begin
            idx <= idx - CW'(1);
          end
        end
        S_DEL: begin
          if (idx + CW'(1) >= count) begin
            count <= count - CW'(1);
            state <= S_OUT;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= ST_OK;
            found     <= 1'b0;
            data_out  <= rd_val;
            last      <= (idx + CW'(1) == count);
            if (idx + CW'(1) == count) state <= S_IDLE;
            idx <= idx + CW'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/sorted_key_value_table_core.sv
// Sorted key/value table core.
// Input channel (valid/stall): func, key, value. One input word is an insert,
// lookup, remove or dump. Output channel (valid/stall): status, found,
// data_out, last. Each other input gives one output word; a dump gives one word
// per stored entry (ascending signed key order) with last on the final one,
// or a single not-found word when the table is empty.
// A two-word queue sits in front, so the sender can hand in the next words
// while the engine works. The engine scans the ordered table one entry per
// cycle from a key/value memory with one read and one write port, then
// shifts entries one per cycle on insert or remove. A dump gives its words
// one per cycle while the receiver does not stall. The engine takes the
// next word in the cycle after the last result word is accepted, so it
// works on one word at a time through its serial scan and shift loop.
// Reset empties the table (count zero); memory contents need no clearing.
// When the receiver stalls, the result word holds and the engine waits;
// the queue keeps taking input until it is full.
`default_nettype none
module sorted_key_value_table_core
  import skvt_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] key,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic                    found,
  output logic signed [31:0]      data_out,
  output logic                    last
);
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_take;

  assign in_cmd = '{func: func_t'(func), key: key, value: value};

  skvt_cmd_fifo u_fifo (
    .clk, .rst, .in_valid, .in_stall, .in_cmd,
    .out_valid(q_valid), .out_take(q_take), .out_cmd(q_cmd)
  );

  skvt_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk, .rst,
    .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
    .out_valid, .out_stall, .status, .found, .data_out, .last
  );
endmodule
`default_nettype wire

FILE: rtl/core/skvt_checker.sv
`default_nettype none
module skvt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic        found,
  input wire logic [31:0] data_out,
  input wire logic        last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(last))
    else $error("stalled output changed");
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == 2'd0 && last)
    else $error("found without ok");
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 2'd0 |-> last && !found && data_out == 32'd0)
    else $error("failure word malformed");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind sorted_key_value_table_core skvt_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .status, .found, .data_out, .last
);
`default_nettype wire
